@@ hdl/bm3d2_pkg.sv @@
// shared constants for the 3x3 box mean decimator
package bm3d2_pkg;

    // pixel and sum widths
    localparam int PIXEL_W = 8;
    localparam int SUM_W   = 10;
    localparam int TOTAL_W = 12;

    // configuration port
    localparam int CFG_ADDR_W   = 1;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;

    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd512;
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd512;

    // row position and height limit
    localparam int ROW_W = 12;
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_LIMIT = 13'd4096;

    // divide by nine: (x * 7282) >> 16 is exact for x below 32768
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;
    localparam int PROD_W = TOTAL_W + RECIP_W;

endpackage

@@ hdl/bm3d2_ram.sv @@
// generic single-port-write, registered-read RAM
module bm3d2_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/box_mean3x3_decimate2_core.sv @@
// 3x3 box mean with clamped borders and decimation by two, top level
//
// Pixels of a frame arrive in raster order, one per clock at full rate. Each
// result is the 3x3 mean (sum / 9, truncated) at an even row and even column,
// with edge pixels replicated at the borders. The edge that takes the pixel
// completing a window loads the window stage; the output register then loads
// through the divide by nine once it is free and presents the result on
// m_tvalid. Two line stores, each MAX_WIDTH pixels rounded up to a power of
// two, are read one pixel ahead of the stream, so the input takes one pixel
// every cycle while the output side is ready. m_tlast marks the last result
// of an output row and m_tuser the last result of the frame.
// Writing either frame-size register restarts the frame; write only while the
// block is idle. The line stores need no clearing after reset.
module box_mean3x3_decimate2_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // config write port
    input  logic                                 cfg_wr_en,
    input  logic [bm3d2_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [bm3d2_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // pixel input
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // [7:0] pixel_in
    // result output
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [7:0]                           m_tdata,   // [7:0] mean_pixel
    output logic                                 m_tlast,   // row_done
    output logic                                 m_tuser    // [0] frame_done
);

    import bm3d2_pkg::*;

    localparam int CW     = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int WCMP_W = (CW + 1 > CFG_WIDTH_W) ? CW + 1 : CFG_WIDTH_W;

    // configuration registers
    logic [CFG_WIDTH_W-1:0]  image_width_reg;
    logic [CFG_HEIGHT_W-1:0] image_height_reg;

    // frame position and column sums
    logic [CW-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [SUM_W-1:0]  sum_mid_reg, sum_mid_next;
    logic [SUM_W-1:0]  sum_right_reg, sum_right_next;

    // window stage
    logic               p1_valid_reg;
    logic [TOTAL_W-1:0] p1_total_reg;
    logic               p1_row_done_reg;
    logic               p1_frame_done_reg;
    logic               p1_ready;

    // output register
    logic               m_valid_reg;
    logic [PIXEL_W-1:0] m_mean_reg;
    logic               m_row_done_reg;
    logic               m_frame_done_reg;

    logic [CW-1:0]      last_col;
    logic [ROW_W-1:0]   last_row;
    logic [WCMP_W-1:0]  width_ext;
    logic               accept;
    logic               is_last_col;
    logic               is_last_row;
    logic               out_row;
    logic               emit;
    logic [PIXEL_W-1:0] above1;
    logic [PIXEL_W-1:0] above2;
    logic [PIXEL_W-1:0] top;
    logic [PIXEL_W-1:0] mid;
    logic [SUM_W-1:0]   col_val;
    logic [TOTAL_W-1:0] total;
    logic [PROD_W-1:0]  product;

    // effective frame size, clamped into range
    assign width_ext = WCMP_W'(image_width_reg);

    always_comb begin
        if (image_width_reg < CFG_WIDTH_W'(2)) begin
            last_col = CW'(1);
        end else if (width_ext > WCMP_W'(MAX_WIDTH)) begin
            last_col = CW'(MAX_WIDTH - 1);
        end else begin
            last_col = CW'(width_ext - WCMP_W'(1));
        end
    end

    always_comb begin
        if (image_height_reg < CFG_HEIGHT_W'(2)) begin
            last_row = ROW_W'(1);
        end else if (image_height_reg > HEIGHT_LIMIT) begin
            last_row = ROW_W'(HEIGHT_LIMIT - CFG_HEIGHT_W'(1));
        end else begin
            last_row = ROW_W'(image_height_reg - CFG_HEIGHT_W'(1));
        end
    end

    // handshake: two-stage pipe, each stage loads when the one after it frees
    assign p1_ready = !m_valid_reg || m_tready;
    assign s_tready = !p1_valid_reg || p1_ready;
    assign accept   = s_tvalid && s_tready;

    assign is_last_col = (col_reg == last_col);
    assign is_last_row = (row_reg == last_row);

    // window rows for the output row this input row serves
    always_comb begin
        if (is_last_row && !row_reg[0]) begin
            out_row = 1'b1;
            top     = above1;
            mid     = s_tdata;
        end else if (row_reg[0]) begin
            out_row = 1'b1;
            top     = (row_reg == ROW_W'(1)) ? above1 : above2;
            mid     = above1;
        end else begin
            out_row = 1'b0;
            top     = above1;
            mid     = above1;
        end
    end

    assign col_val = SUM_W'(top) + SUM_W'(mid) + SUM_W'(s_tdata);

    // 3x3 total of held column sums and the new one, doubled at the right edge
    always_comb begin
        if (col_reg[0]) begin
            emit  = out_row;
            total = TOTAL_W'(sum_mid_reg) + TOTAL_W'(sum_right_reg) + TOTAL_W'(col_val);
        end else if (is_last_col) begin
            emit  = out_row;
            total = TOTAL_W'(sum_right_reg) + TOTAL_W'(col_val) + TOTAL_W'(col_val);
        end else begin
            emit  = 1'b0;
            total = '0;
        end
    end

    // next position and column sums
    always_comb begin
        col_next       = col_reg;
        row_next       = row_reg;
        sum_mid_next   = sum_mid_reg;
        sum_right_next = sum_right_reg;
        if (cfg_wr_en) begin
            col_next       = '0;
            row_next       = '0;
            sum_mid_next   = '0;
            sum_right_next = '0;
        end else if (accept) begin
            if (col_reg == '0) begin
                sum_mid_next = col_val;
            end else begin
                sum_mid_next = sum_right_reg;
            end
            sum_right_next = col_val;
            if (is_last_col) begin
                col_next = '0;
                row_next = is_last_row ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    // line stores, read one pixel ahead at the next column
    bm3d2_ram #(
        .DATA_W (PIXEL_W),
        .DEPTH  (2 ** CW)
    ) u_older_row (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (above1),
        .rd_addr (col_next),
        .rd_data (above2)
    );

    bm3d2_ram #(
        .DATA_W (PIXEL_W),
        .DEPTH  (2 ** CW)
    ) u_newer_row (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (s_tdata),
        .rd_addr (col_next),
        .rd_data (above1)
    );

    // config registers, position and column sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
            col_reg          <= '0;
            row_reg          <= '0;
            sum_mid_reg      <= '0;
            sum_right_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata[CFG_WIDTH_W-1:0];
                    CFG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata[CFG_HEIGHT_W-1:0];
                    default: ;
                endcase
            end
            col_reg       <= col_next;
            row_reg       <= row_next;
            sum_mid_reg   <= sum_mid_next;
            sum_right_reg <= sum_right_next;
        end
    end

    // window stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            p1_valid_reg <= accept && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            p1_total_reg      <= total;
            p1_row_done_reg   <= is_last_col;
            p1_frame_done_reg <= is_last_col && is_last_row;
        end
    end

    // divide by nine through the reciprocal
    assign product = PROD_W'(p1_total_reg) * PROD_W'(RECIP_NINE);

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p1_ready) begin
            m_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_ready && p1_valid_reg) begin
            m_mean_reg       <= product[RECIP_SHIFT +: PIXEL_W];
            m_row_done_reg   <= p1_row_done_reg;
            m_frame_done_reg <= p1_frame_done_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_mean_reg;
    assign m_tlast  = m_row_done_reg;
    assign m_tuser  = m_frame_done_reg;

endmodule
